// ===== design/uleb_pkg.sv =====
// Shared types and constants for the ULEB128 index locator.
package uleb_pkg;

   localparam int unsigned IDX_W     = 32;
   localparam int unsigned ACC_W     = 64;
   localparam int unsigned SHIFT_W   = 7;
   localparam int unsigned SPLIT_W   = 13;
   localparam int unsigned SUBDICT_W = 23;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned DIV_STEPS = IDX_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [6:0]         PAYLOAD_MASK  = 7'h7f;
   localparam logic [SHIFT_W-1:0] BITS_PER_BYTE = 7'd7;
   localparam logic [SPLIT_W-1:0] SPLIT_MIN     = 13'd1000;
   localparam logic [SPLIT_W-1:0] SPLIT_MAX     = 13'd5000;

   // register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_DICT_TOTAL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT_SIZE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_DIVIDE = 2'd1,
      ST_RESULT = 2'd2
   } state_type;

   typedef struct packed {
      logic take_byte;
      logic div_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic code_done;
      logic div_last;
      logic rsp_free;
   } sts_type;

endpackage

// ===== design/uleb_ctrl.sv =====
// Controller state machine: byte intake, division sequencing and result hand-off.
module uleb_ctrl
   import uleb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && sts.code_done) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (sts.div_last) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (sts.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            cmd.take_byte = req_valid;
         end
         ST_DIVIDE: cmd.div_step = 1'b1;
         ST_RESULT: cmd.load_rsp = sts.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

// ===== design/uleb_datapath.sv =====
// Datapath: config registers, ULEB128 accumulator, serial divider and result register.
module uleb_datapath
   import uleb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [IDX_W-1:0]     csr_write_data,
   input  logic [7:0]           req_code_byte,
   input  logic                 req_string_end,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [IDX_W-1:0]     rsp_string_index,
   output logic [SUBDICT_W-1:0] rsp_subdict_number,
   output logic [SPLIT_W-1:0]   rsp_entry_position,
   output logic                 rsp_status,
   input  cmd_type              cmd,
   output sts_type              sts
);

   logic [IDX_W-1:0]     dict_total_ff;
   logic [SPLIT_W-1:0]   split_size_ff;
   logic [ACC_W-1:0]     acc_ff;
   logic [ACC_W-1:0]     acc_in;
   logic [SHIFT_W-1:0]   shift_ff;
   logic [SHIFT_W-1:0]   shift_in;
   logic                 halt_ff;
   logic                 halt_in;
   logic [IDX_W-1:0]     index_ff;
   logic                 err_ff;
   logic [SPLIT_W-1:0]   split_ff;
   logic [IDX_W-1:0]     quo_ff;
   logic [SPLIT_W-1:0]   rem_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 rsp_valid_ff;

   logic [ACC_W-1:0]     acc_upd;
   logic [SHIFT_W-1:0]   shift_upd;
   logic                 code_err;
   logic [SPLIT_W-1:0]   split_eff;
   logic [SPLIT_W:0]     trial;
   logic                 trial_ge;
   logic [SPLIT_W:0]     trial_diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dict_total_ff <= '0;
         split_size_ff <= SPLIT_MIN;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DICT_TOTAL: dict_total_ff <= csr_write_data;
            CSR_SPLIT_SIZE: split_size_ff <= csr_write_data[SPLIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (split_size_ff < SPLIT_MIN) begin
         split_eff = SPLIT_MIN;
      end else if (split_size_ff > SPLIT_MAX) begin
         split_eff = SPLIT_MAX;
      end else begin
         split_eff = split_size_ff;
      end
   end

   // payload bits past bit 63 fall off; shift freezes once it reaches 64 or more
   always_comb begin
      acc_upd   = acc_ff;
      shift_upd = shift_ff;
      if (!shift_ff[SHIFT_W-1]) begin
         acc_upd   = acc_ff | ({{(ACC_W-7){1'b0}}, req_code_byte[6:0] & PAYLOAD_MASK}
                               << shift_ff[SHIFT_W-2:0]);
         shift_upd = shift_ff + BITS_PER_BYTE;
      end
   end

   assign code_err = (acc_upd == '0) || (acc_upd[ACC_W-1:IDX_W] != '0)
                     || (acc_upd[IDX_W-1:0] > dict_total_ff);

   assign sts.code_done = !halt_ff && !req_code_byte[7];
   assign sts.div_last  = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign sts.rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      acc_in   = acc_ff;
      shift_in = shift_ff;
      halt_in  = halt_ff;
      if (cmd.take_byte) begin
         if (!halt_ff) begin
            acc_in   = acc_upd;
            shift_in = shift_upd;
            if (!req_code_byte[7]) begin
               acc_in   = '0;
               shift_in = '0;
               halt_in  = code_err;
            end
         end
         if (req_string_end) begin
            acc_in   = '0;
            shift_in = '0;
            halt_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         shift_ff <= '0;
         halt_ff  <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         shift_ff <= shift_in;
         halt_ff  <= halt_in;
      end
   end

   // restoring divider, one quotient bit per cycle
   assign trial      = {rem_ff, quo_ff[IDX_W-1]};
   assign trial_ge   = (trial >= {1'b0, split_ff});
   assign trial_diff = trial - {1'b0, split_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.take_byte) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_byte && sts.code_done) begin
         index_ff <= acc_upd[IDX_W-1:0];
         err_ff   <= code_err;
         split_ff <= split_eff;
         quo_ff   <= acc_upd[IDX_W-1:0] - 1'b1;
         rem_ff   <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[IDX_W-2:0], trial_ge};
         rem_ff <= trial_ge ? trial_diff[SPLIT_W-1:0] : trial[SPLIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_string_index   <= index_ff;
         rsp_status         <= err_ff;
         rsp_subdict_number <= err_ff ? '0 : quo_ff[SUBDICT_W-1:0] + 1'b1;
         rsp_entry_position <= err_ff ? '0 : rem_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/uleb_index_to_subdict_locator.sv =====
// Top level of the ULEB128 string index decoder and sub-dictionary locator.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | code_byte, string_end
//   rsp     | out       | rsp_valid/stall    | string_index, subdict_number,
//           |           |                    | entry_position, status
//   csr     | in        | csr_write_enable   | csr_index, csr_write_data
//
// A byte that does not complete a code is taken while idle. A completed code is
// accepted, divided by the split size in the one-bit-per-cycle divider and then
// loaded into the result register. Reset is synchronous and active high and clears
// the accumulator and halt. A result that is stalled stays in the output register
// while the next bytes are taken; a following code waits at the end of its division
// until that register frees.
module uleb_index_to_subdict_locator
   import uleb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [IDX_W-1:0]     csr_write_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_code_byte,
   input  logic                 req_string_end,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [IDX_W-1:0]     rsp_string_index,
   output logic [SUBDICT_W-1:0] rsp_subdict_number,
   output logic [SPLIT_W-1:0]   rsp_entry_position,
   output logic                 rsp_status
);

   cmd_type cmd;
   sts_type sts;

   uleb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   uleb_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_code_byte      (req_code_byte),
      .req_string_end     (req_string_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_string_index   (rsp_string_index),
      .rsp_subdict_number (rsp_subdict_number),
      .rsp_entry_position (rsp_entry_position),
      .rsp_status         (rsp_status),
      .cmd                (cmd),
      .sts                (sts)
   );

endmodule

// ===== design/uleb_checker.sv =====
// Port-level checks for the ULEB128 index locator, bound to the top level.
module uleb_checker
   import uleb_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [IDX_W-1:0]     rsp_string_index,
   input logic [SUBDICT_W-1:0] rsp_subdict_number,
   input logic [SPLIT_W-1:0]   rsp_entry_position,
   input logic                 rsp_status
);

   // hold the result while the far side stalls
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_string_index)
         && $stable(rsp_subdict_number) && $stable(rsp_entry_position)
         && $stable(rsp_status))
      else $error("result changed during stall");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_subdict_number == '0 && rsp_entry_position == '0)
      else $error("error result carries a location");

   a_ok_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_status |-> rsp_subdict_number != '0 && rsp_string_index != '0)
      else $error("valid result with zero index or sub-dictionary");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_status |-> rsp_entry_position < SPLIT_MAX)
      else $error("entry position beyond largest split");

   // a new result only appears after the input side was held for the division
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a division");

endmodule

bind uleb_index_to_subdict_locator uleb_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_string_index   (rsp_string_index),
   .rsp_subdict_number (rsp_subdict_number),
   .rsp_entry_position (rsp_entry_position),
   .rsp_status         (rsp_status)
);
